// File: hdl/clp_pkg.sv
// Shared types and constants for the clipped line pixel generator.
package clp_pkg;

    // Default geometry parameters
    localparam int COORD_BITS_DEF = 12;
    localparam int PITCH_BITS_DEF = 15;

    // Fixed field and register widths
    localparam int OFFSET_BITS    = 26;
    localparam int COLOR_BITS     = 32;
    localparam int SCREEN_BITS    = 13;
    localparam int ROW_PITCH_BITS = 15;
    localparam int BPP_BITS       = 3;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 15;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE          = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_PITCH       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BYTES_PER_PIXEL = 3'd4;

    // Request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // Pixel sizes and their color masks
    localparam logic [BPP_BITS-1:0] BPP_NONE  = 3'd0;
    localparam logic [BPP_BITS-1:0] BPP_1     = 3'd1;
    localparam logic [BPP_BITS-1:0] BPP_2     = 3'd2;
    localparam logic [BPP_BITS-1:0] BPP_3     = 3'd3;
    localparam logic [BPP_BITS-1:0] BPP_4     = 3'd4;
    localparam logic [BPP_BITS-1:0] BPP_RESET = BPP_4;

    localparam logic [COLOR_BITS-1:0] MASK_8  = 32'h0000_00FF;
    localparam logic [COLOR_BITS-1:0] MASK_16 = 32'h0000_FFFF;
    localparam logic [COLOR_BITS-1:0] MASK_24 = 32'h00FF_FFFF;
    localparam logic [COLOR_BITS-1:0] MASK_32 = 32'hFFFF_FFFF;

    // Configuration seen by the datapath (row pitch travels apart, its width is a parameter)
    typedef struct packed {
        logic                   enable;
        logic [SCREEN_BITS-1:0] screen_width;
        logic [SCREEN_BITS-1:0] screen_height;
        logic [BPP_BITS-1:0]    bytes_per_pixel;
    } cfg_t;

    // Control bits of a point between walker and address stage
    typedef struct packed {
        logic last;
        logic idle;
    } pt_ctl_t;

endpackage

// File: hdl/clp_req_if.sv
// Request channel: start and step beats for the line walker.
interface clp_req_if
    import clp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();

    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [COLOR_BITS-1:0] line_color;

    modport source (
        output valid, req_type, x_start, y_start, x_end, y_end, line_color,
        input  ready
    );

    modport sink (
        input  valid, req_type, x_start, y_start, x_end, y_end, line_color,
        output ready
    );

endinterface

// File: hdl/clp_pix_if.sv
// Pixel channel: one point beat per accepted request.
interface clp_pix_if
    import clp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();

    logic                   valid;
    logic                   ready;
    logic [COORD_BITS-1:0]  point_x;
    logic [COORD_BITS-1:0]  point_y;
    logic [OFFSET_BITS-1:0] byte_offset;
    logic [COLOR_BITS-1:0]  pixel_data;
    logic                   write_enable;
    logic                   last_point;
    logic                   idle;

    modport source (
        output valid, point_x, point_y, byte_offset, pixel_data, write_enable,
               last_point, idle,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, byte_offset, pixel_data, write_enable,
               last_point, idle,
        output ready
    );

endinterface

// File: hdl/clp_walker.sv
// Bresenham walker stage: line state and one registered point per request.
module clp_walker
    import clp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    clp_req_if.sink               req,
    output logic                  pt_valid,
    input  logic                  pt_ready,
    output logic [COORD_BITS-1:0] pt_x,
    output logic [COORD_BITS-1:0] pt_y,
    output logic [COLOR_BITS-1:0] pt_color,
    output pt_ctl_t               pt_ctl,
    output logic                  line_active
);

    localparam int EW = COORD_BITS + 3;

    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0] end_x_reg, end_x_next;
    logic [COORD_BITS-1:0] end_y_reg, end_y_next;
    logic [COORD_BITS-1:0] delta_x_reg, delta_x_next;
    logic [COORD_BITS-1:0] delta_y_reg, delta_y_next;
    logic                  x_backward_reg, x_backward_next;
    logic                  y_backward_reg, y_backward_next;
    logic signed [EW-1:0]  error_term_reg, error_term_next;
    logic [COLOR_BITS-1:0] held_color_reg, held_color_next;
    logic                  line_active_reg, line_active_next;

    logic                  valid_reg;
    logic [COORD_BITS-1:0] pt_x_reg;
    logic [COORD_BITS-1:0] pt_y_reg;
    logic [COLOR_BITS-1:0] pt_color_reg;
    pt_ctl_t               pt_ctl_reg, pt_ctl_next;

    logic                  accept;
    logic [COORD_BITS-1:0] dx_start, dy_start;
    logic signed [EW:0]    e2, neg_dy, dx_wide;
    logic signed [EW-1:0]  dx_ext, dy_ext;
    logic                  x_move, y_move;

    // Take a new beat whenever the point register is free or drains this cycle
    assign req.ready = !valid_reg || pt_ready;
    assign accept    = req.valid && req.ready;

    // Start-of-line deltas
    assign dx_start = (req.x_end > req.x_start) ? req.x_end - req.x_start
                                                : req.x_start - req.x_end;
    assign dy_start = (req.y_end > req.y_start) ? req.y_end - req.y_start
                                                : req.y_start - req.y_end;

    // Step decisions from the doubled error term
    assign e2      = $signed({error_term_reg, 1'b0});
    assign neg_dy  = -$signed({4'b0000, delta_y_reg});
    assign dx_wide = $signed({4'b0000, delta_x_reg});
    assign dx_ext  = $signed({3'b000, delta_x_reg});
    assign dy_ext  = $signed({3'b000, delta_y_reg});
    assign x_move  = e2 > neg_dy;
    assign y_move  = e2 < dx_wide;

    // Next line state and emitted point
    always_comb
    begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        end_x_next      = end_x_reg;
        end_y_next      = end_y_reg;
        delta_x_next    = delta_x_reg;
        delta_y_next    = delta_y_reg;
        x_backward_next = x_backward_reg;
        y_backward_next = y_backward_reg;
        error_term_next = error_term_reg;
        held_color_next = held_color_reg;
        line_active_next = line_active_reg;
        pt_ctl_next.last = 1'b0;
        pt_ctl_next.idle = 1'b1;

        if (!cfg.enable)
        begin
            line_active_next = 1'b0;
        end
        else if (req.req_type == REQ_START)
        begin
            cur_x_next      = req.x_start;
            cur_y_next      = req.y_start;
            end_x_next      = req.x_end;
            end_y_next      = req.y_end;
            delta_x_next    = dx_start;
            delta_y_next    = dy_start;
            x_backward_next = !(req.x_start < req.x_end);
            y_backward_next = !(req.y_start < req.y_end);
            error_term_next = $signed({3'b000, dx_start}) - $signed({3'b000, dy_start});
            held_color_next = req.line_color;
            pt_ctl_next.last = (req.x_start == req.x_end) && (req.y_start == req.y_end);
            pt_ctl_next.idle = 1'b0;
            line_active_next = !pt_ctl_next.last;
        end
        else if (line_active_reg)
        begin
            if (x_move)
            begin
                cur_x_next = x_backward_reg ? cur_x_reg - COORD_BITS'(1)
                                            : cur_x_reg + COORD_BITS'(1);
            end
            if (y_move)
            begin
                cur_y_next = y_backward_reg ? cur_y_reg - COORD_BITS'(1)
                                            : cur_y_reg + COORD_BITS'(1);
            end
            error_term_next = error_term_reg - (x_move ? dy_ext : '0)
                                             + (y_move ? dx_ext : '0);
            pt_ctl_next.last = (cur_x_next == end_x_reg) && (cur_y_next == end_y_reg);
            pt_ctl_next.idle = 1'b0;
            if (pt_ctl_next.last)
            begin
                line_active_next = 1'b0;
            end
        end
    end

    // Line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            end_x_reg       <= '0;
            end_y_reg       <= '0;
            delta_x_reg     <= '0;
            delta_y_reg     <= '0;
            x_backward_reg  <= 1'b0;
            y_backward_reg  <= 1'b0;
            error_term_reg  <= '0;
            held_color_reg  <= '0;
            line_active_reg <= 1'b0;
        end
        else if (accept)
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            end_x_reg       <= end_x_next;
            end_y_reg       <= end_y_next;
            delta_x_reg     <= delta_x_next;
            delta_y_reg     <= delta_y_next;
            x_backward_reg  <= x_backward_next;
            y_backward_reg  <= y_backward_next;
            error_term_reg  <= error_term_next;
            held_color_reg  <= held_color_next;
            line_active_reg <= line_active_next;
        end
    end

    // Point register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    // Point payload, held while the next stage stalls
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pt_x_reg     <= cur_x_next;
            pt_y_reg     <= cur_y_next;
            pt_color_reg <= held_color_next;
            pt_ctl_reg   <= pt_ctl_next;
        end
    end

    assign pt_valid    = valid_reg;
    assign pt_x        = pt_x_reg;
    assign pt_y        = pt_y_reg;
    assign pt_color    = pt_color_reg;
    assign pt_ctl      = pt_ctl_reg;
    assign line_active = line_active_reg;

endmodule

// File: hdl/clp_addr.sv
// Address stage: byte offset, pixel data and clipping into the result register.
module clp_addr
    import clp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int PITCH_W    = ROW_PITCH_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic [PITCH_W-1:0]    row_pitch,
    input  logic                  pt_valid,
    output logic                  pt_ready,
    input  logic [COORD_BITS-1:0] pt_x,
    input  logic [COORD_BITS-1:0] pt_y,
    input  logic [COLOR_BITS-1:0] pt_color,
    input  pt_ctl_t               pt_ctl,
    clp_pix_if.source             pix
);

    localparam int PY_W   = COORD_BITS + PITCH_W;
    localparam int PX_W   = COORD_BITS + BPP_BITS;
    localparam int SUM_W  = ((PY_W > OFFSET_BITS) ? PY_W : OFFSET_BITS) + 1;
    localparam int CMP_W  = (COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS;

    logic                   valid_reg;
    logic [COORD_BITS-1:0]  x_reg;
    logic [COORD_BITS-1:0]  y_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [COLOR_BITS-1:0]  data_reg;
    logic                   we_reg;
    logic                   last_reg;
    logic                   idle_reg;

    logic [PY_W-1:0]        prod_y;
    logic [PX_W-1:0]        prod_x;
    logic [SUM_W-1:0]       off_sum;
    logic [COLOR_BITS-1:0]  data_mask;
    logic                   size_ok;
    logic                   on_screen;
    logic                   load;

    assign pt_ready = !valid_reg || pix.ready;
    assign load     = pt_valid && pt_ready;

    // Offset y*pitch + x*bytes_per_pixel, wrapped to the offset width
    assign prod_y  = PY_W'(pt_y) * PY_W'(row_pitch);
    assign prod_x  = PX_W'(pt_x) * PX_W'(cfg.bytes_per_pixel);
    assign off_sum = SUM_W'(prod_y) + SUM_W'(prod_x);

    // Truncate the color to the pixel width
    always_comb
    begin
        size_ok   = 1'b1;
        data_mask = '0;
        case (cfg.bytes_per_pixel)
            BPP_1:   data_mask = MASK_8;
            BPP_2:   data_mask = MASK_16;
            BPP_3:   data_mask = MASK_24;
            BPP_4:   data_mask = MASK_32;
            default: size_ok   = 1'b0;
        endcase
    end

    // Clip against the visible screen
    assign on_screen = (CMP_W'(pt_x) < CMP_W'(cfg.screen_width)) &&
                       (CMP_W'(pt_y) < CMP_W'(cfg.screen_height));

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pt_ready)
        begin
            valid_reg <= pt_valid;
        end
    end

    // Result payload; an idle beat reports zeros
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            idle_reg <= pt_ctl.idle;
            if (pt_ctl.idle)
            begin
                x_reg      <= '0;
                y_reg      <= '0;
                offset_reg <= '0;
                data_reg   <= '0;
                we_reg     <= 1'b0;
                last_reg   <= 1'b0;
            end
            else
            begin
                x_reg      <= pt_x;
                y_reg      <= pt_y;
                offset_reg <= off_sum[OFFSET_BITS-1:0];
                data_reg   <= pt_color & data_mask;
                we_reg     <= size_ok && on_screen;
                last_reg   <= pt_ctl.last;
            end
        end
    end

    assign pix.valid        = valid_reg;
    assign pix.point_x      = x_reg;
    assign pix.point_y      = y_reg;
    assign pix.byte_offset  = offset_reg;
    assign pix.pixel_data   = data_reg;
    assign pix.write_enable = we_reg;
    assign pix.last_point   = last_reg;
    assign pix.idle         = idle_reg;

endmodule

// File: hdl/clipped_line_pixel_generator_core.sv
// Top level of the clipped line pixel generator: config registers, walker and address stage.
//
// Each request beat yields exactly one point beat, and a new request is taken every cycle
// while the pixel channel is ready (one point per cycle sustained). A beat is registered
// first in the Bresenham walker, where the error-term add/compare updates the line state
// and registers the point, and then in the address stage, where the y*pitch multiply plus
// x*bytes_per_pixel add forms the byte offset and the clip and color mask are applied.
// A start beat emits the first point, each step beat the next; with enable low any beat,
// and with no line active a step, returns an idle beat. Configuration writes take effect
// at the next edge and are meant to be made while no beat is in flight.
module clipped_line_pixel_generator_core
    import clp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int PITCH_BITS = PITCH_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wen,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    clp_req_if.sink                   req,
    clp_pix_if.source                 pix
);

    localparam int PITCH_W = (PITCH_BITS < ROW_PITCH_BITS) ? PITCH_BITS : ROW_PITCH_BITS;

    cfg_t                  cfg_reg;
    logic [PITCH_W-1:0]    row_pitch_reg;

    logic                  pt_valid;
    logic                  pt_ready;
    logic [COORD_BITS-1:0] pt_x;
    logic [COORD_BITS-1:0] pt_y;
    logic [COLOR_BITS-1:0] pt_color;
    pt_ctl_t               pt_ctl;
    logic                  line_active;

    // Decode configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable          <= 1'b0;
            cfg_reg.screen_width    <= '0;
            cfg_reg.screen_height   <= '0;
            cfg_reg.bytes_per_pixel <= BPP_RESET;
            row_pitch_reg           <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_ENABLE:          cfg_reg.enable          <= cfg_data[0];
                REG_SCREEN_WIDTH:    cfg_reg.screen_width    <= cfg_data[SCREEN_BITS-1:0];
                REG_SCREEN_HEIGHT:   cfg_reg.screen_height   <= cfg_data[SCREEN_BITS-1:0];
                REG_ROW_PITCH:       row_pitch_reg           <= cfg_data[PITCH_W-1:0];
                REG_BYTES_PER_PIXEL: cfg_reg.bytes_per_pixel <= cfg_data[BPP_BITS-1:0];
                default:             ;
            endcase
        end
    end

    clp_walker #(
        .COORD_BITS (COORD_BITS)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .req         (req),
        .pt_valid    (pt_valid),
        .pt_ready    (pt_ready),
        .pt_x        (pt_x),
        .pt_y        (pt_y),
        .pt_color    (pt_color),
        .pt_ctl      (pt_ctl),
        .line_active (line_active)
    );

    clp_addr #(
        .COORD_BITS (COORD_BITS),
        .PITCH_W    (PITCH_W)
    ) u_addr (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .row_pitch (row_pitch_reg),
        .pt_valid  (pt_valid),
        .pt_ready  (pt_ready),
        .pt_x      (pt_x),
        .pt_y      (pt_y),
        .pt_color  (pt_color),
        .pt_ctl    (pt_ctl),
        .pix       (pix)
    );

    // A beat taken while disabled drops any line
    a_disable_drops_line: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && !cfg_reg.enable) |=> !line_active)
        else $error("line still active after a beat taken while disabled");

    // A step with no line leaves the walker without a line
    a_step_without_line: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.req_type == REQ_STEP && !line_active)
        |=> !line_active)
        else $error("step without a line started one");

    // An unsupported pixel size never writes
    a_bad_size_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && (cfg_reg.bytes_per_pixel == BPP_NONE ||
                       cfg_reg.bytes_per_pixel > BPP_4))
        |-> !pix.write_enable)
        else $error("write enable set with an unsupported pixel size");

    // An idle beat carries no write and no last mark
    a_idle_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.idle) |-> (!pix.write_enable && !pix.last_point))
        else $error("idle beat with write enable or last mark");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the clipped line pixel generator core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import clp_pkg::*;

    localparam int CRD             = COORD_BITS_DEF;
    localparam int COORD_MAX       = (1 << CRD) - 1;
    localparam int QUIET_LIMIT     = 2000;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int MAX_PRINTED     = 30;

    // Pixel sizes the block must reject
    localparam logic [BPP_BITS-1:0] BPP_5    = 3'd5;
    localparam logic [BPP_BITS-1:0] BPP_MAX  = 3'd7;

    typedef struct {
        logic                  rtype;
        logic [CRD-1:0]        xs;
        logic [CRD-1:0]        ys;
        logic [CRD-1:0]        xe;
        logic [CRD-1:0]        ye;
        logic [COLOR_BITS-1:0] color;
    } line_req_t;

    typedef struct {
        logic [CRD-1:0]         px;
        logic [CRD-1:0]         py;
        logic [OFFSET_BITS-1:0] offset;
        logic [COLOR_BITS-1:0]  data;
        logic                   wen;
        logic                   last;
        logic                   idle;
    } pixel_beat_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_wen;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    clp_req_if req_ch ();
    clp_pix_if pix_ch ();

    clipped_line_pixel_generator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .pix       (pix_ch)
    );

    // Shadow copy of the configuration registers
    logic                      sh_enable = 1'b0;
    logic [SCREEN_BITS-1:0]    sh_width  = '0;
    logic [SCREEN_BITS-1:0]    sh_height = '0;
    logic [ROW_PITCH_BITS-1:0] sh_pitch  = '0;
    logic [BPP_BITS-1:0]       sh_bpp    = BPP_RESET;

    // Shadow copy of the line walker
    logic [CRD-1:0]        ln_x      = '0;
    logic [CRD-1:0]        ln_y      = '0;
    logic [CRD-1:0]        ln_end_x  = '0;
    logic [CRD-1:0]        ln_end_y  = '0;
    int                    ln_dx     = 0;
    int                    ln_dy     = 0;
    int                    ln_err    = 0;
    logic                  ln_x_back = 1'b0;
    logic                  ln_y_back = 1'b0;
    logic [COLOR_BITS-1:0] ln_color  = '0;
    logic                  ln_active = 1'b0;

    line_req_t   pending_reqs[$];
    pixel_beat_t expected_points[$];
    line_req_t   presented;

    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct  = 0;
    int          mismatches      = 0;
    int          beats_checked   = 0;
    int          idle_beats      = 0;
    int          masked_beats    = 0;
    int          lines_started   = 0;
    int          settings_used   = 0;
    int          quiet_cycles    = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic pixel_beat_t idle_beat();
        pixel_beat_t beat;
        beat = '{default: '0};
        beat.idle = 1'b1;
        return beat;
    endfunction

    // Form the point at the walker position with the current register values
    function automatic pixel_beat_t point_beat(logic last);
        pixel_beat_t beat;
        logic        size_ok;
        logic [63:0] off;
        beat = '{default: '0};
        size_ok = 1'b1;
        case (sh_bpp)
            BPP_1:   beat.data = ln_color & MASK_8;
            BPP_2:   beat.data = ln_color & MASK_16;
            BPP_3:   beat.data = ln_color & MASK_24;
            BPP_4:   beat.data = ln_color & MASK_32;
            default: size_ok = 1'b0;
        endcase
        off = 64'(ln_y) * 64'(sh_pitch) + 64'(ln_x) * 64'(sh_bpp);
        beat.px     = ln_x;
        beat.py     = ln_y;
        beat.offset = off[OFFSET_BITS-1:0];
        beat.wen    = size_ok && (ln_x < sh_width) && (ln_y < sh_height);
        beat.last   = last;
        beat.idle   = 1'b0;
        return beat;
    endfunction

    // Advance the shadow walker by one request and return the point it yields
    function automatic pixel_beat_t advance_line(line_req_t r);
        int   e2;
        logic last;
        if (!sh_enable)
        begin
            ln_active = 1'b0;
            return idle_beat();
        end
        if (r.rtype == REQ_START)
        begin
            ln_x      = r.xs;
            ln_y      = r.ys;
            ln_end_x  = r.xe;
            ln_end_y  = r.ye;
            ln_dx     = (r.xe > r.xs) ? int'(r.xe - r.xs) : int'(r.xs - r.xe);
            ln_dy     = (r.ye > r.ys) ? int'(r.ye - r.ys) : int'(r.ys - r.ye);
            ln_x_back = !(r.xs < r.xe);
            ln_y_back = !(r.ys < r.ye);
            ln_err    = ln_dx - ln_dy;
            ln_color  = r.color;
        end
        else
        begin
            if (!ln_active)
                return idle_beat();
            e2 = 2 * ln_err;
            if (e2 > -ln_dy)
            begin
                ln_err = ln_err - ln_dy;
                ln_x   = ln_x_back ? ln_x - 1'b1 : ln_x + 1'b1;
            end
            if (e2 < ln_dx)
            begin
                ln_err = ln_err + ln_dx;
                ln_y   = ln_y_back ? ln_y - 1'b1 : ln_y + 1'b1;
            end
        end
        last = (ln_x == ln_end_x) && (ln_y == ln_end_y);
        ln_active = !last;
        return point_beat(last);
    endfunction

    function automatic line_req_t start_req(int x0, int y0, int x1, int y1,
                                            logic [COLOR_BITS-1:0] color);
        line_req_t r;
        r.rtype = REQ_START;
        r.xs    = x0[CRD-1:0];
        r.ys    = y0[CRD-1:0];
        r.xe    = x1[CRD-1:0];
        r.ye    = y1[CRD-1:0];
        r.color = color;
        return r;
    endfunction

    // Step beats carry random payload that the block must ignore
    function automatic line_req_t step_req();
        line_req_t r;
        r = start_req($urandom, $urandom, $urandom, $urandom, $urandom);
        r.rtype = REQ_STEP;
        return r;
    endfunction

    // Pick an endpoint within span of s, kept on the coordinate range
    function automatic int end_near(int s, int span);
        int d;
        int e;
        d = int'($urandom_range(0, 2 * span)) - span;
        e = s + d;
        if (e < 0 || e > COORD_MAX)
            e = s - d;
        if (e < 0)
            e = 0;
        if (e > COORD_MAX)
            e = COORD_MAX;
        return e;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic set_register(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_ENABLE:          sh_enable = value[0];
            REG_SCREEN_WIDTH:    sh_width  = value[SCREEN_BITS-1:0];
            REG_SCREEN_HEIGHT:   sh_height = value[SCREEN_BITS-1:0];
            REG_ROW_PITCH:       sh_pitch  = value[ROW_PITCH_BITS-1:0];
            REG_BYTES_PER_PIXEL: sh_bpp    = value[BPP_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(int unsigned en, int unsigned w, int unsigned h,
                                int unsigned pitch, int unsigned bpp);
        set_register(REG_ENABLE, CFG_DATA_BITS'(en));
        set_register(REG_SCREEN_WIDTH, CFG_DATA_BITS'(w));
        set_register(REG_SCREEN_HEIGHT, CFG_DATA_BITS'(h));
        set_register(REG_ROW_PITCH, CFG_DATA_BITS'(pitch));
        set_register(REG_BYTES_PER_PIXEL, CFG_DATA_BITS'(bpp));
        @(posedge clk);
        cfg_wen <= 1'b0;
        settings_used++;
        @(negedge clk);
    endtask

    // Hold until every queued request is taken and every point has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || req_ch.valid || expected_points.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Mostly whole short lines with random content, some abandoned, some overrun, some noise
    task automatic queue_random_lines(int unsigned n_items);
        int unsigned counted;
        int          x0;
        int          y0;
        int          x1;
        int          y1;
        int          span;
        int          steps;
        line_req_t   r;
        counted = 0;
        while (counted < n_items)
        begin
            if ($urandom_range(99) < 12)
            begin
                r = step_req();
                r.rtype = 1'($urandom_range(1));
                pending_reqs.push_back(r);
                counted++;
            end
            else
            begin
                span = ($urandom_range(99) < 8) ? COORD_MAX : 12;
                x0 = $urandom_range(COORD_MAX);
                y0 = $urandom_range(COORD_MAX);
                x1 = end_near(x0, span);
                y1 = end_near(y0, span);
                steps = (x1 > x0) ? x1 - x0 : x0 - x1;
                if (((y1 > y0) ? y1 - y0 : y0 - y1) > steps)
                    steps = (y1 > y0) ? y1 - y0 : y0 - y1;
                if (span == COORD_MAX)
                    steps = $urandom_range(20);
                else if ($urandom_range(99) < 20)
                    steps = $urandom_range(steps + 3);
                pending_reqs.push_back(start_req(x0, y0, x1, y1, $urandom));
                counted += 1 + steps;
                repeat (steps) pending_reqs.push_back(step_req());
            end
        end
    endtask

    // Drive request beats from the pending queue, predict each accepted one
    always @(posedge clk)
    begin : driver
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_points.push_back(advance_line(presented));
                if (presented.rtype == REQ_START)
                    lines_started++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    presented = pending_reqs.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.req_type   <= presented.rtype;
                    req_ch.x_start    <= presented.xs;
                    req_ch.y_start    <= presented.ys;
                    req_ch.x_end      <= presented.xe;
                    req_ch.y_end      <= presented.ye;
                    req_ch.line_color <= presented.color;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Check each accepted point beat against the oldest prediction
    always @(posedge clk)
    begin : monitor
        pixel_beat_t want;
        if (rst_n)
        begin
            if (pix_ch.valid && pix_ch.ready)
            begin
                if (expected_points.size() == 0)
                begin
                    report_mismatch("point beat with nothing expected");
                end
                else
                begin
                    want = expected_points.pop_front();
                    beats_checked++;
                    if (want.idle)
                        idle_beats++;
                    else if (!want.wen)
                        masked_beats++;
                    if (pix_ch.point_x !== want.px)
                        report_mismatch($sformatf("point_x got %0d want %0d",
                                                  pix_ch.point_x, want.px));
                    if (pix_ch.point_y !== want.py)
                        report_mismatch($sformatf("point_y got %0d want %0d",
                                                  pix_ch.point_y, want.py));
                    if (pix_ch.byte_offset !== want.offset)
                        report_mismatch($sformatf("byte_offset got %0h want %0h",
                                                  pix_ch.byte_offset, want.offset));
                    if (pix_ch.pixel_data !== want.data)
                        report_mismatch($sformatf("pixel_data got %0h want %0h",
                                                  pix_ch.pixel_data, want.data));
                    if (pix_ch.write_enable !== want.wen)
                        report_mismatch($sformatf("write_enable got %b want %b",
                                                  pix_ch.write_enable, want.wen));
                    if (pix_ch.last_point !== want.last)
                        report_mismatch($sformatf("last_point got %b want %b",
                                                  pix_ch.last_point, want.last));
                    if (pix_ch.idle !== want.idle)
                        report_mismatch($sformatf("idle got %b want %b",
                                                  pix_ch.idle, want.idle));
                end
            end
            pix_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // End the run when neither channel moves a beat for too long
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (pix_ch.valid && pix_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no beat moved in %0d cycles", QUIET_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int ph;
        rst_n             = 1'b0;
        cfg_wen           = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_START;
        req_ch.x_start    = '0;
        req_ch.y_start    = '0;
        req_ch.x_end      = '0;
        req_ch.y_end      = '0;
        req_ch.line_color = '0;
        pix_ch.ready      = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Out of reset the block is disabled: a start yields only idle
        @(negedge clk);
        pending_reqs.push_back(start_req(1, 2, 3, 4, 32'hDEAD_BEEF));
        pending_reqs.push_back(step_req());
        wait_drained();

        // Directed lines on a screen that covers the whole coordinate range
        apply_config(1, 4096, 4096, 16384, BPP_4);
        pending_reqs.push_back(step_req());
        pending_reqs.push_back(start_req(0, 0, 0, 0, 32'hFFFF_FFFF));
        pending_reqs.push_back(step_req());
        pending_reqs.push_back(start_req(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'h0));
        pending_reqs.push_back(start_req(0, 0, 3, 1, 32'h1234_5678));
        repeat (4) pending_reqs.push_back(step_req());
        pending_reqs.push_back(start_req(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX - 4,
                                         32'hA5A5_A5A5));
        repeat (4) pending_reqs.push_back(step_req());
        pending_reqs.push_back(start_req(10, 10, 20, 20, 32'h5A5A_5A5A));
        pending_reqs.push_back(step_req());
        pending_reqs.push_back(start_req(5, 7, 5, 9, 32'h00C0_FFEE));
        repeat (2) pending_reqs.push_back(step_req());
        pending_reqs.push_back(start_req(0, COORD_MAX, COORD_MAX, 0, 32'h8000_0001));
        repeat (2) pending_reqs.push_back(step_req());
        pending_reqs.push_back(start_req(COORD_MAX, 0, 0, COORD_MAX, 32'h7FFF_FFFE));
        pending_reqs.push_back(step_req());
        wait_drained();

        // Random phases, each under its own register setting and one of four idling patterns
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 4)
                0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin sender_idle_pct = 53; recv_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin sender_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            case (ph)
                0: apply_config(1, 0, 0, 0, BPP_1);
                1: apply_config(1, 8191, 8191, 32767, BPP_MAX);
                2: apply_config(0, $urandom_range(4096), $urandom_range(4096),
                                $urandom_range(16384), BPP_2);
                3: apply_config(1, $urandom_range(4096), $urandom_range(4096),
                                $urandom_range(32767), BPP_NONE);
                4: apply_config(1, $urandom_range(4096), $urandom_range(4096),
                                $urandom_range(16384), BPP_5 + $urandom_range(1));
                default: apply_config(1, $urandom_range(4096), $urandom_range(4096),
                                      $urandom_range(16384), $urandom_range(BPP_1, BPP_4));
            endcase
            // The first step continues, or finds dropped, the line left over from before
            pending_reqs.push_back(step_req());
            queue_random_lines(ITEMS_PER_PHASE);
            pending_reqs.push_back(start_req(0, 0, COORD_MAX, COORD_MAX, $urandom));
            pending_reqs.push_back(step_req());
            wait_drained();
        end

        repeat (10) @(posedge clk);
        $display("Checked %0d point beats from %0d line starts over %0d register settings,",
                 beats_checked, lines_started, settings_used);
        $display("%0d of them idle and %0d with the write cleared; %0d mismatches.",
                 idle_beats, masked_beats, mismatches);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
